// ----- hdl/ilir_pkg.sv -----
package ilir_pkg;

  // Fixed geometry of the list; the field widths of the word channels are written as literals that match it.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned DATA_W   = 32;

  // Operation codes.
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_SWAP   = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // Read address selects.
  localparam logic [1:0] RSEL_IDX    = 2'd0;
  localparam logic [1:0] RSEL_IDX2   = 2'd1;
  localparam logic [1:0] RSEL_PTR_M1 = 2'd2;
  localparam logic [1:0] RSEL_PTR_P1 = 2'd3;

  // Write address selects.
  localparam logic [1:0] WSEL_IDX  = 2'd0;
  localparam logic [1:0] WSEL_IDX2 = 2'd1;
  localparam logic [1:0] WSEL_PTR  = 2'd2;

  // Write data selects.
  localparam logic [1:0] DSEL_VAL   = 2'd0;
  localparam logic [1:0] DSEL_RDATA = 2'd1;
  localparam logic [1:0] DSEL_HOLD  = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic [8:0]         index;
    logic [7:0]         second_index;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [8:0]         entry_count;
    logic [1:0]         status;
  } rsp_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       ptr_load_ins;
    logic       ptr_load_rem;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       mem_re;
    logic [1:0] raddr_sel;
    logic       mem_we;
    logic [1:0] waddr_sel;
    logic [1:0] wdata_sel;
    logic       hold_load;
    logic       count_inc;
    logic       count_dec;
    logic       result_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       ok;
    logic       ptr_at_idx;
    logic       rem_more;
    logic       rsp_free;
  } sts_t;

endpackage

// ----- hdl/indexed_list_insert_remove_core.sv -----
// Bounded ordered list of up to 256 signed 32-bit entries held in a single-port-write,
// single-port-read RAM, with a live entry count. Each command word carries one
// operation (read, overwrite, insert with shift, remove with shift, swap) and
// produces exactly one response word with the read value, the count after the
// operation and a status (ok, bad index, empty, full). The block works on one
// command at a time: command stall is high from acceptance until the response is
// loaded into the output register, which lets a new command in while an earlier
// response still waits. Read, overwrite, errors and unused codes go from the check
// state to the finish state, swap passes the states SWP_A and SWP_B, and insert
// and remove loop over a test and a move state: each shifted entry costs one RAM
// read and one RAM write, the loop ends with one more test of the shift pointer,
// and a stalled response holds the finish state. Entries need no clearing after
// reset: only positions below the count are ever read, and every such position
// was written.
module indexed_list_insert_remove_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ilir_pkg::cmd_word_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ilir_pkg::rsp_word_t rsp
);
  import ilir_pkg::*;

  // Command and status groups between the sequencer and the datapath.
  ctl_t ctl;
  sts_t sts;

  // The controller steps through the shift loops and sequences the RAM ports.
  ilir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // The datapath holds the command, the count, the shift pointer, the RAM
  // and the response register.
  ilir_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

// ----- hdl/ilir_ram.sv -----
module ilir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/ilir_ctrl.sv -----
module ilir_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ilir_pkg::sts_t sts,
  output ilir_pkg::ctl_t ctl
);
  import ilir_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_INS_TEST = 4'd2;
  localparam logic [3:0] S_INS_MOVE = 4'd3;
  localparam logic [3:0] S_REM_TEST = 4'd4;
  localparam logic [3:0] S_REM_MOVE = 4'd5;
  localparam logic [3:0] S_SWP_A    = 4'd6;
  localparam logic [3:0] S_SWP_B    = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.raddr_sel = RSEL_IDX;
    ctl.waddr_sel = WSEL_IDX;
    ctl.wdata_sel = DSEL_VAL;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.ok) begin
          state_next = S_FINISH;
        end else begin
          unique case (sts.op)
            OP_READ: begin
              ctl.mem_re    = 1'b1;
              ctl.raddr_sel = RSEL_IDX;
              state_next    = S_FINISH;
            end
            OP_INSERT: begin
              ctl.ptr_load_ins = 1'b1;
              state_next       = S_INS_TEST;
            end
            OP_REMOVE: begin
              ctl.ptr_load_rem = 1'b1;
              state_next       = S_REM_TEST;
            end
            OP_SWAP: begin
              ctl.mem_re    = 1'b1;
              ctl.raddr_sel = RSEL_IDX;
              state_next    = S_SWP_A;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_INS_TEST: begin
        if (sts.ptr_at_idx) begin
          state_next = S_FINISH;
        end else begin
          ctl.mem_re    = 1'b1;
          ctl.raddr_sel = RSEL_PTR_M1;
          state_next    = S_INS_MOVE;
        end
      end
      S_INS_MOVE: begin
        ctl.mem_we    = 1'b1;
        ctl.waddr_sel = WSEL_PTR;
        ctl.wdata_sel = DSEL_RDATA;
        ctl.ptr_dec   = 1'b1;
        state_next    = S_INS_TEST;
      end
      S_REM_TEST: begin
        if (sts.rem_more) begin
          ctl.mem_re    = 1'b1;
          ctl.raddr_sel = RSEL_PTR_P1;
          state_next    = S_REM_MOVE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_REM_MOVE: begin
        ctl.mem_we    = 1'b1;
        ctl.waddr_sel = WSEL_PTR;
        ctl.wdata_sel = DSEL_RDATA;
        ctl.ptr_inc   = 1'b1;
        state_next    = S_REM_TEST;
      end
      S_SWP_A: begin
        // First entry arrives now; park it and fetch the second one.
        ctl.hold_load = 1'b1;
        ctl.mem_re    = 1'b1;
        ctl.raddr_sel = RSEL_IDX2;
        state_next    = S_SWP_B;
      end
      S_SWP_B: begin
        ctl.mem_we    = 1'b1;
        ctl.waddr_sel = WSEL_IDX;
        ctl.wdata_sel = DSEL_RDATA;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (sts.rsp_free) begin
          ctl.result_load = 1'b1;
          state_next      = S_IDLE;
          if (sts.ok) begin
            unique case (sts.op)
              OP_WRITE: begin
                ctl.mem_we    = 1'b1;
                ctl.waddr_sel = WSEL_IDX;
                ctl.wdata_sel = DSEL_VAL;
              end
              OP_INSERT: begin
                ctl.mem_we    = 1'b1;
                ctl.waddr_sel = WSEL_IDX;
                ctl.wdata_sel = DSEL_VAL;
                ctl.count_inc = 1'b1;
              end
              OP_REMOVE: begin
                ctl.count_dec = 1'b1;
              end
              OP_SWAP: begin
                ctl.mem_we    = 1'b1;
                ctl.waddr_sel = WSEL_IDX2;
                ctl.wdata_sel = DSEL_HOLD;
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A move always writes the data fetched in the cycle before.
  a_move_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_MOVE || state == S_REM_MOVE) |-> $past(ctl.mem_re))
    else $error("entry move without a preceding read");

  // The result register is only loaded when it is free.
  a_result_free: assert property (@(posedge clk) disable iff (rst)
    ctl.result_load |-> sts.rsp_free)
    else $error("result loaded over a pending word");

endmodule

// ----- hdl/ilir_dp.sv -----
module ilir_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  ilir_pkg::cmd_word_t  cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output ilir_pkg::rsp_word_t  rsp,
  input  ilir_pkg::ctl_t       ctl,
  output ilir_pkg::sts_t       sts
);
  import ilir_pkg::*;

  cmd_word_t            item;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic [ADDR_W-1:0]    ptr;
  logic [DATA_W-1:0]    hold;
  logic [DATA_W-1:0]    rdata;
  logic [1:0]           stat;
  logic                 idx_lt;
  logic                 idx2_lt;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  logic [DATA_W-1:0]    wdata;
  logic [COUNT_W-1:0]   ptr_p1_wide;

  // Range checks against the count before the operation.
  assign idx_lt      = item.index < count;
  assign idx2_lt     = {1'b0, item.second_index} < count;
  assign ptr_p1_wide = {1'b0, ptr} + COUNT_W'(1);

  always_comb begin
    stat = STAT_OK;
    unique case (item.operation) inside
      OP_READ, OP_WRITE: begin
        if (!idx_lt) stat = STAT_BAD_INDEX;
      end
      OP_INSERT: begin
        if (item.index > count) begin
          stat = STAT_BAD_INDEX;
        end else if (count == COUNT_W'(CAPACITY)) begin
          stat = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        if (count == '0) begin
          stat = STAT_EMPTY;
        end else if (!idx_lt) begin
          stat = STAT_BAD_INDEX;
        end
      end
      OP_SWAP: begin
        if (!idx_lt || !idx2_lt) stat = STAT_BAD_INDEX;
      end
      default: begin
        stat = STAT_OK;
      end
    endcase
  end

  assign sts.op         = item.operation;
  assign sts.ok         = (stat == STAT_OK);
  assign sts.ptr_at_idx = (ptr == item.index[ADDR_W-1:0]);
  assign sts.rem_more   = ptr_p1_wide < count;
  assign sts.rsp_free   = !rsp_valid || !rsp_stall;

  always_comb begin
    case (ctl.raddr_sel)
      RSEL_IDX:    raddr = item.index[ADDR_W-1:0];
      RSEL_IDX2:   raddr = item.second_index;
      RSEL_PTR_M1: raddr = ptr - ADDR_W'(1);
      default:     raddr = ptr + ADDR_W'(1);
    endcase
    case (ctl.waddr_sel)
      WSEL_IDX:  waddr = item.index[ADDR_W-1:0];
      WSEL_IDX2: waddr = item.second_index;
      default:   waddr = ptr;
    endcase
    case (ctl.wdata_sel)
      DSEL_VAL:   wdata = item.value;
      DSEL_RDATA: wdata = rdata;
      default:    wdata = hold;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctl.count_inc) begin
      count_next = count + COUNT_W'(1);
    end else if (ctl.count_dec) begin
      count_next = count - COUNT_W'(1);
    end
  end

  ilir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (ctl.result_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= cmd;
    end
    if (ctl.ptr_load_ins) begin
      ptr <= count[ADDR_W-1:0];
    end else if (ctl.ptr_load_rem) begin
      ptr <= item.index[ADDR_W-1:0];
    end else if (ctl.ptr_dec) begin
      ptr <= ptr - ADDR_W'(1);
    end else if (ctl.ptr_inc) begin
      ptr <= ptr + ADDR_W'(1);
    end
    if (ctl.hold_load) begin
      hold <= rdata;
    end
    if (ctl.result_load) begin
      rsp.read_value  <= (item.operation == OP_READ && stat == STAT_OK) ?
                         $signed(rdata) : '0;
      rsp.entry_count <= count_next;
      rsp.status      <= stat;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_only_at_result: assert property (@(posedge clk) disable iff (rst)
    !ctl.result_load |=> $stable(count))
    else $error("entry count changed outside a result");

endmodule
